>>> hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the tile lookup block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

>>> hw/rtl/stsl_pkg.sv
// Package with types and constants of the sorted tile subset lookup block.
`timescale 1ns / 1ps
`default_nettype none

package stsl_pkg;

  localparam int TILE_W   = 32;
  localparam int MASK_W   = 64;
  localparam int IMAGE_W  = 32;
  localparam int INDEX_W  = 12;
  localparam int COUNT_W  = 13;
  localparam int ENTRY_W  = TILE_W + MASK_W + IMAGE_W;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // register index (byte address bit 2)
  localparam logic REG_ENTRY_COUNT = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_PROBE,
    ST_DOWN,
    ST_DOWN_CMP,
    ST_UP,
    ST_UP_CMP,
    ST_SCAN,
    ST_SCAN_CMP,
    ST_FETCH,
    ST_RESULT
  } state_t;

  typedef enum logic [1:0] {
    ADDR_MID,
    ADDR_LOW,
    ADDR_HIGH,
    ADDR_FINAL
  } addr_src_t;

  typedef enum logic [2:0] {
    LOW_HOLD,
    LOW_PIVOT_INC,
    LOW_PIVOT_DEC,
    LOW_DEC,
    LOW_INC,
    LOW_FROM_HIGH
  } low_op_t;

  typedef enum logic [2:0] {
    HIGH_HOLD,
    HIGH_PIVOT_DEC,
    HIGH_PIVOT_INC,
    HIGH_INC,
    HIGH_DEC
  } high_op_t;

  typedef struct packed {
    logic      wr_en;
    logic      start_lookup;
    logic      rd_en;
    addr_src_t rd_src;
    low_op_t   low_op;
    high_op_t  high_op;
    logic      pivot_load;
    logic      hit_set;
  } ctrl_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic search_open;
    logic tile_lt;
    logic tile_gt;
    logic tile_eq;
    logic low_neg;
    logic high_at_end;
    logic scan_open;
    logic mask_subset;
  } dp_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/stsl_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module stsl_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/stsl_dp.sv
// Datapath: entry RAM, search bounds, query registers and compare logic.
`timescale 1ns / 1ps
`default_nettype none

module stsl_dp import stsl_pkg::*; #(
  parameter int TABLE_DEPTH = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ctrl_cmd_t           cmd,
  output      dp_status_t          status,
  input  wire logic [COUNT_W-1:0]  entry_count,
  input  wire logic [INDEX_W-1:0]  entry_index,
  input  wire logic [TILE_W-1:0]   tile_number,
  input  wire logic [MASK_W-1:0]   subst_mask,
  input  wire logic [IMAGE_W-1:0]  image_value,
  output      logic [IMAGE_W-1:0]  image_index,
  output      logic                exact_match
);

  localparam int AW = $clog2(TABLE_DEPTH);
  // positions run from -1 up to the depth, signed
  localparam int PW = AW + 2;

  logic [TILE_W-1:0]    q_tile;
  logic [MASK_W-1:0]    q_mask;
  logic signed [PW-1:0] n;
  logic signed [PW-1:0] low;
  logic signed [PW-1:0] high;
  logic signed [PW-1:0] pivot;
  logic                 hit;

  logic signed [PW-1:0] n_calc;
  logic signed [PW:0]   sum;
  logic signed [PW-1:0] mid;
  logic signed [PW-1:0] final_pos;
  logic signed [PW-1:0] low_next;
  logic signed [PW-1:0] high_next;

  logic               wr_ok;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] rdata;
  logic [TILE_W-1:0]  rd_tile;
  logic [MASK_W-1:0]  rd_mask;
  logic [IMAGE_W-1:0] rd_image;

  // count above the depth acts as the depth
  always_comb begin
    if (32'(entry_count) > 32'(TABLE_DEPTH)) begin
      n_calc = PW'(TABLE_DEPTH);
    end else begin
      n_calc = PW'(entry_count);
    end
  end

  assign sum = low + high;
  assign mid = sum[PW:1];

  // clamp the search end into the table
  always_comb begin
    if (low >= n) begin
      final_pos = n - PW'(1);
    end else if (low[PW-1]) begin
      final_pos = '0;
    end else begin
      final_pos = low;
    end
  end

  assign wr_ok = cmd.wr_en && (32'(entry_index) < 32'(TABLE_DEPTH));
  assign waddr = AW'(entry_index);
  assign wdata = {tile_number, subst_mask, image_value};

  always_comb begin
    case (cmd.rd_src)
      ADDR_MID:   raddr = AW'(mid);
      ADDR_LOW:   raddr = AW'(low);
      ADDR_HIGH:  raddr = AW'(high);
      ADDR_FINAL: raddr = AW'(final_pos);
      default:    raddr = AW'(final_pos);
    endcase
  end

  stsl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (wr_ok),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.rd_en),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd_tile  = rdata[ENTRY_W-1 -: TILE_W];
  assign rd_mask  = rdata[IMAGE_W +: MASK_W];
  assign rd_image = rdata[IMAGE_W-1:0];

  always_comb begin
    case (cmd.low_op)
      LOW_HOLD:      low_next = low;
      LOW_PIVOT_INC: low_next = pivot + PW'(1);
      LOW_PIVOT_DEC: low_next = pivot - PW'(1);
      LOW_DEC:       low_next = low - PW'(1);
      LOW_INC:       low_next = low + PW'(1);
      LOW_FROM_HIGH: low_next = high;
      default:       low_next = low;
    endcase
    case (cmd.high_op)
      HIGH_HOLD:      high_next = high;
      HIGH_PIVOT_DEC: high_next = pivot - PW'(1);
      HIGH_PIVOT_INC: high_next = pivot + PW'(1);
      HIGH_INC:       high_next = high + PW'(1);
      HIGH_DEC:       high_next = high - PW'(1);
      default:        high_next = high;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.start_lookup) begin
      q_tile <= tile_number;
      q_mask <= subst_mask;
      n      <= n_calc;
      low    <= '0;
      high   <= n_calc;
    end else begin
      low  <= low_next;
      high <= high_next;
    end
    if (cmd.pivot_load) begin
      pivot <= mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (cmd.start_lookup) begin
      hit <= 1'b0;
    end else if (cmd.hit_set) begin
      hit <= 1'b1;
    end
  end

  assign status.count_zero  = (entry_count == '0);
  assign status.search_open = (low < high);
  assign status.tile_lt     = (rd_tile < q_tile);
  assign status.tile_gt     = (rd_tile > q_tile);
  assign status.tile_eq     = (rd_tile == q_tile);
  assign status.low_neg     = low[PW-1];
  assign status.high_at_end = (high >= n);
  assign status.scan_open   = (high >= low);
  assign status.mask_subset = ((rd_mask & q_mask) == rd_mask);

  assign image_index = rd_image;
  assign exact_match = hit;

endmodule

`default_nettype wire

>>> hw/rtl/stsl_ctrl.sv
// Controller: state machine that issues table writes and sequences search, run widening and mask scan.
`timescale 1ns / 1ps
`default_nettype none

module stsl_ctrl import stsl_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic       operation,
  input  wire dp_status_t status,
  output      ctrl_cmd_t  cmd,
  output      logic       busy,
  output      logic       done
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    cmd.wr_en        = 1'b0;
    cmd.start_lookup = 1'b0;
    cmd.rd_en        = 1'b0;
    cmd.rd_src       = ADDR_FINAL;
    cmd.low_op       = LOW_HOLD;
    cmd.high_op      = HIGH_HOLD;
    cmd.pivot_load   = 1'b0;
    cmd.hit_set      = 1'b0;
    done             = 1'b0;
    busy             = (state != ST_IDLE);

    case (state)
      ST_IDLE: begin
        if (start) begin
          if (operation == OP_WRITE) begin
            cmd.wr_en = 1'b1;
          end else if (!status.count_zero) begin
            cmd.start_lookup = 1'b1;
            state_next       = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (status.search_open) begin
          cmd.rd_en      = 1'b1;
          cmd.rd_src     = ADDR_MID;
          cmd.pivot_load = 1'b1;
          state_next     = ST_PROBE;
        end else begin
          state_next = ST_FETCH;
        end
      end
      ST_PROBE: begin
        if (status.tile_lt) begin
          cmd.low_op = LOW_PIVOT_INC;
          state_next = ST_SEARCH;
        end else if (status.tile_gt) begin
          cmd.high_op = HIGH_PIVOT_DEC;
          state_next  = ST_SEARCH;
        end else begin
          // tile found: widen to its run, pivot itself is known equal
          cmd.low_op  = LOW_PIVOT_DEC;
          cmd.high_op = HIGH_PIVOT_INC;
          state_next  = ST_DOWN;
        end
      end
      ST_DOWN: begin
        if (status.low_neg) begin
          cmd.low_op = LOW_INC;
          state_next = ST_UP;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = ADDR_LOW;
          state_next = ST_DOWN_CMP;
        end
      end
      ST_DOWN_CMP: begin
        if (status.tile_eq) begin
          cmd.low_op = LOW_DEC;
          state_next = ST_DOWN;
        end else begin
          cmd.low_op = LOW_INC;
          state_next = ST_UP;
        end
      end
      ST_UP: begin
        if (status.high_at_end) begin
          cmd.high_op = HIGH_DEC;
          state_next  = ST_SCAN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = ADDR_HIGH;
          state_next = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        if (status.tile_eq) begin
          cmd.high_op = HIGH_INC;
          state_next  = ST_UP;
        end else begin
          cmd.high_op = HIGH_DEC;
          state_next  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // high walks down the run as the scan cursor
        if (status.scan_open) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = ADDR_HIGH;
          state_next = ST_SCAN_CMP;
        end else begin
          state_next = ST_FETCH;
        end
      end
      ST_SCAN_CMP: begin
        if (status.mask_subset) begin
          cmd.low_op  = LOW_FROM_HIGH;
          cmd.hit_set = 1'b1;
          state_next  = ST_FETCH;
        end else begin
          cmd.high_op = HIGH_DEC;
          state_next  = ST_SCAN;
        end
      end
      ST_FETCH: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = ADDR_FINAL;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/sorted_tile_subset_lookup.sv
// Top level of the sorted tile subset lookup block.
//
// Usage: an item is taken at a rising edge with start high and busy low.
// operation selects a table write or a lookup. A write stores tile number,
// mask and image value at entry_index in the cycle it is taken, gives no
// result and leaves busy low, so writes may follow back to back. Entries
// beyond the table depth are dropped.
// A lookup raises busy and runs on the entry RAM, whose single read port
// sets the pace: each binary search probe, each step of widening the run
// and each step of the mask scan is a read, then a compare. The search
// makes at most about log2(entry_count) + 1 probes. On a find, widening
// reads down and then up from the found entry and the scan walks down the
// run from its top; a final read then fetches the result entry, also when
// the search or the scan ends without a match. done is high for one cycle
// with image_index and exact_match; the receiver cannot stall, busy drops
// in the next cycle, and the next item can be taken then at the earliest.
// A lookup with entry_count zero gives no result. entry_count lives in an
// APB register at address 0 and must be written only while idle. Reset
// clears the controller and entry_count; table contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sorted_tile_subset_lookup import stsl_pkg::*; #(
  parameter int TABLE_DEPTH = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output      logic [CFG_DATA_W-1:0] prdata,
  output      logic                  pready,
  input  wire logic                  start,
  output      logic                  busy,
  input  wire logic                  operation,
  input  wire logic [INDEX_W-1:0]    entry_index,
  input  wire logic [TILE_W-1:0]     tile_number,
  input  wire logic [MASK_W-1:0]     subst_mask,
  input  wire logic [IMAGE_W-1:0]    image_value,
  output      logic                  done,
  output      logic [IMAGE_W-1:0]    image_index,
  output      logic                  exact_match
);

  logic [COUNT_W-1:0] entry_count;
  logic               cfg_write;
  logic               lookup_take;
  logic               write_take;
  ctrl_cmd_t          cmd;
  dp_status_t         status;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  assign lookup_take = start && !busy && (operation == OP_LOOKUP);
  assign write_take  = start && !busy && (operation == OP_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_write && (paddr[2] == REG_ENTRY_COUNT)) begin
      entry_count <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_ENTRY_COUNT) begin
      prdata = CFG_DATA_W'(entry_count);
    end else begin
      prdata = '0;
    end
  end

  stsl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .operation(operation),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done)
  );

  stsl_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .entry_count(entry_count),
    .entry_index(entry_index),
    .tile_number(tile_number),
    .subst_mask (subst_mask),
    .image_value(image_value),
    .image_index(image_index),
    .exact_match(exact_match)
  );

  `ASSERT_PROP(a_done_while_busy, clk, rst, done |-> busy, "result strobe outside a lookup")
  `ASSERT_NEXT(a_idle_after_done, clk, rst, done, !busy, "busy held after result")
  `ASSERT_PROP(a_busy_from_lookup, clk, rst, $rose(busy) |-> $past(lookup_take), "stray busy")
  `ASSERT_NEXT(a_write_stays_idle, clk, rst, write_take, !busy, "write item made the block busy")

endmodule

`default_nettype wire
